>>> src/dusc_pkg.sv
// ----------------------------------------------------------------------------
// dusc_pkg: shared types and constants
// Segment codes, register map and the result beat layout of the debounced
// up/down counter with seven-segment scan.
// ----------------------------------------------------------------------------
package dusc_pkg;

    localparam int NUM_BUTTONS = 4;

    localparam int BTN_PLUS   = 0;
    localparam int BTN_MINUS  = 1;
    localparam int BTN_SELECT = 2;
    localparam int BTN_ALT    = 3;

    localparam logic REG_DEBOUNCE_TICKS = 1'b0;
    localparam logic REG_MAX_COUNT      = 1'b1;

    localparam logic [3:0] DEBOUNCE_TICKS_RESET = 4'd2;
    localparam logic [6:0] MAX_COUNT_RESET      = 7'd12;

    localparam logic [1:0] SCAN_TENS   = 2'd0;
    localparam logic [1:0] SCAN_UNITS  = 2'd1;
    localparam logic [1:0] SCAN_FIVE   = 2'd2;
    localparam logic [1:0] SCAN_LETTER = 2'd3;

    localparam logic [3:0] GLYPH_FIVE     = 4'd5;
    localparam logic [3:0] GLYPH_LETTER_H = 4'd10;

    localparam logic [7:0] SEG_TABLE [11] = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92,
        8'h82, 8'hf8, 8'h80, 8'h90, 8'h8b
    };

    typedef struct packed {
        logic       alt_event;
        logic       select_event;
        logic [6:0] count_value;
        logic [3:0] digit_select;
        logic [7:0] segment_pattern;
    } result_t;

endpackage

>>> src/debounced_updown_counter_7seg_scan.sv
// ----------------------------------------------------------------------------
// debounced_updown_counter_7seg_scan
// Debounces four buttons per tick, steps a saturating up/down count and
// drives one digit of a multiplexed seven-segment display per tick.
// ----------------------------------------------------------------------------
// Each input beat is one timer tick and yields exactly one result beat. The
// tick is processed in the cycle it is accepted and its result appears in the
// output register on the next cycle, so one tick per clock cycle is sustained;
// a new tick is accepted whenever the output register is empty or being taken.
// ----------------------------------------------------------------------------
module debounced_updown_counter_7seg_scan
    import dusc_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: plus_level, minus_level, select_level, alt_level.
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: segment_pattern[7:0], digit_select[3:0],
    // count_value[6:0], select_event, alt_event.
    output logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TW   = TICK_COUNT_WIDTH;
    localparam int LIMW = (TW > 4) ? TW : 4;
    localparam logic [LIMW-1:0] TICK_MASK = LIMW'((1 << TW) - 1);

    logic [3:0]    debounce_ticks_reg;
    logic [6:0]    max_count_reg;
    logic [TW-1:0] press_ticks_reg [NUM_BUTTONS];
    logic [TW-1:0] press_ticks_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] idle_reg, idle_next;
    logic [NUM_BUTTONS-1:0] conf_reg, conf_next;
    logic [NUM_BUTTONS-1:0] fire;
    logic [6:0]    count_reg, count_next;
    logic [1:0]    scan_reg, scan_next;
    logic          m_tvalid_reg;
    result_t       result_reg, result_next;

    logic          s_accept;
    logic          cfg_write;
    logic [LIMW-1:0] limit_wide;
    logic [TW-1:0] limit;
    logic [6:0]    shown_mod;
    logic [14:0]   tens_product;
    logic [3:0]    tens_digit;
    logic [3:0]    units_digit;
    logic [3:0]    glyph;
    logic [6:0]    count_step;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {3'b000, result_reg};

    always_comb begin
        case (paddr[2])
            REG_DEBOUNCE_TICKS: prdata = {28'd0, debounce_ticks_reg};
            REG_MAX_COUNT:      prdata = {25'd0, max_count_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_comb begin
        limit_wide = LIMW'(debounce_ticks_reg);
        if (limit_wide > TICK_MASK) begin
            limit_wide = TICK_MASK;
        end
        limit = limit_wide[TW-1:0];
    end

    always_comb begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            press_ticks_next[b] = press_ticks_reg[b];
            idle_next[b] = idle_reg[b];
            conf_next[b] = conf_reg[b];
            fire[b] = 1'b0;
            if (s_tdata[b]) begin
                if (idle_reg[b]) begin
                    press_ticks_next[b] = '0;
                    idle_next[b] = 1'b0;
                end else begin
                    if (press_ticks_reg[b] < limit) begin
                        press_ticks_next[b] = press_ticks_reg[b] + 1'b1;
                        conf_next[b] = 1'b0;
                    end
                    if (press_ticks_next[b] >= limit) begin
                        fire[b] = !conf_next[b];
                        conf_next[b] = 1'b1;
                    end
                end
            end else if (conf_reg[b]) begin
                conf_next[b] = 1'b0;
                idle_next[b] = 1'b1;
                press_ticks_next[b] = '0;
            end
        end
    end

    always_comb begin
        count_step = count_reg;
        if (fire[BTN_PLUS]) begin
            count_step = (count_reg < max_count_reg) ? count_reg + 7'd1 : max_count_reg;
        end
        count_next = count_step;
        if (fire[BTN_MINUS] && count_step != 7'd0) begin
            count_next = count_step - 7'd1;
        end
    end

    always_comb begin
        shown_mod    = (count_reg >= 7'd100) ? count_reg - 7'd100 : count_reg;
        tens_product = 15'(shown_mod) * 15'd205;
        tens_digit   = tens_product[14:11];
        units_digit  = 4'(shown_mod - 7'(tens_digit) * 7'd10);
        scan_next    = scan_reg + 2'd1;
        case (scan_next)
            SCAN_TENS:   glyph = tens_digit;
            SCAN_UNITS:  glyph = units_digit;
            SCAN_FIVE:   glyph = GLYPH_FIVE;
            SCAN_LETTER: glyph = GLYPH_LETTER_H;
            default:     glyph = GLYPH_LETTER_H;
        endcase
        result_next.segment_pattern = SEG_TABLE[glyph];
        result_next.digit_select    = 4'(4'd1 << scan_next);
        result_next.count_value     = count_next;
        result_next.select_event    = fire[BTN_SELECT];
        result_next.alt_event       = fire[BTN_ALT];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg <= DEBOUNCE_TICKS_RESET;
            max_count_reg      <= MAX_COUNT_RESET;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                press_ticks_reg[b] <= '0;
            end
            idle_reg     <= '1;
            conf_reg     <= '0;
            count_reg    <= 7'd0;
            scan_reg     <= SCAN_TENS;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (paddr[2])
                    REG_DEBOUNCE_TICKS: debounce_ticks_reg <= pwdata[3:0];
                    REG_MAX_COUNT:      max_count_reg <= pwdata[6:0];
                    default:            ;
                endcase
            end
            if (s_accept) begin
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    press_ticks_reg[b] <= press_ticks_next[b];
                end
                idle_reg  <= idle_next;
                conf_reg  <= conf_next;
                count_reg <= count_next;
                scan_reg  <= scan_next;
            end
            if (s_accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    // An accepted tick always lands in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid_reg)
        else $error("accepted tick did not produce a result beat");

    // The scan moves by exactly one digit per accepted tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> scan_reg == 2'($past(scan_reg) + 2'd1))
        else $error("scan position did not advance by one");

    // A held result beat shows exactly one digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> $onehot(result_reg.digit_select))
        else $error("digit select is not one-hot");

    // A confirmed press belongs to a counter that is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (idle_reg & conf_reg) == '0)
        else $error("idle debounce counter marked as confirmed");

    // Without an accepted tick the count holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(count_reg))
        else $error("count changed without an accepted tick");

endmodule

>>> sim/debounced_updown_counter_7seg_scan_tb.sv
// ----------------------------------------------------------------------------
// debounced_updown_counter_7seg_scan_tb
// Drives button ticks into the debounced up/down counter and checks every
// display beat against a cycle-free model of debounce, count and digit scan.
// Configuration changes between phases move the threshold and the count limit
// through their extremes while both stream sides stall at random.
// ----------------------------------------------------------------------------
module debounced_updown_counter_7seg_scan_tb;
    import dusc_pkg::*;

    localparam int TICK_W = 4;
    localparam int TICK_MAX = (1 << TICK_W) - 1;

    class tick_predictor;
        logic [3:0]        threshold;
        logic [6:0]        count_limit;
        logic [TICK_W-1:0] press_ticks [NUM_BUTTONS];
        bit                idle [NUM_BUTTONS];
        bit                confirmed [NUM_BUTTONS];
        logic [6:0]        count;
        logic [1:0]        scan;
        result_t           awaited_digits [$];
        int                mismatches;

        function new();
            threshold = DEBOUNCE_TICKS_RESET;
            count_limit = MAX_COUNT_RESET;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                press_ticks[b] = '0;
                idle[b] = 1'b1;
                confirmed[b] = 1'b0;
            end
            count = '0;
            scan = SCAN_TENS;
            mismatches = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == REG_DEBOUNCE_TICKS) begin
                threshold = value[3:0];
            end else begin
                count_limit = value[6:0];
            end
        endfunction

        function bit debounce_step(int b, bit level);
            int limit;
            bit fire;
            limit = int'(threshold);
            if (limit > TICK_MAX) begin
                limit = TICK_MAX;
            end
            fire = 1'b0;
            if (level) begin
                if (idle[b]) begin
                    press_ticks[b] = '0;
                    idle[b] = 1'b0;
                end else begin
                    if (press_ticks[b] < limit) begin
                        press_ticks[b] = press_ticks[b] + 1'b1;
                        confirmed[b] = 1'b0;
                    end
                    if (press_ticks[b] >= limit) begin
                        if (!confirmed[b]) begin
                            fire = 1'b1;
                        end
                        confirmed[b] = 1'b1;
                    end
                end
            end else if (confirmed[b]) begin
                confirmed[b] = 1'b0;
                idle[b] = 1'b1;
                press_ticks[b] = '0;
            end
            return fire;
        endfunction

        function logic [7:0] glyph(int unsigned digit);
            case (digit)
                0: return ~8'h3f;
                1: return ~8'h06;
                2: return ~8'h5b;
                3: return ~8'h4f;
                4: return ~8'h66;
                5: return ~8'h6d;
                6: return ~8'h7d;
                7: return ~8'h07;
                8: return ~8'h7f;
                9: return ~8'h6f;
                default: return ~8'h74;
            endcase
        endfunction

        function void note_tick(logic [3:0] levels);
            logic [6:0]  shown;
            bit          pressed [NUM_BUTTONS];
            int unsigned digit;
            result_t     r;
            shown = count;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                pressed[b] = debounce_step(b, levels[b]);
            end
            if (pressed[BTN_PLUS]) begin
                count = (count < count_limit) ? count + 7'd1 : count_limit;
            end
            if (pressed[BTN_MINUS] && count != 0) begin
                count = count - 7'd1;
            end
            scan = scan + 2'd1;
            case (scan)
                SCAN_TENS:  digit = (shown % 100) / 10;
                SCAN_UNITS: digit = shown % 10;
                SCAN_FIVE:  digit = 32'(GLYPH_FIVE);
                default:    digit = 32'(GLYPH_LETTER_H);
            endcase
            r.segment_pattern = glyph(digit);
            r.digit_select = 4'b0001 << scan;
            r.count_value = count;
            r.select_event = pressed[BTN_SELECT];
            r.alt_event = pressed[BTN_ALT];
            awaited_digits.push_back(r);
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_digit_beat(result_t got);
            result_t want;
            if (awaited_digits.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = awaited_digits.pop_front();
            if (got.segment_pattern !== want.segment_pattern) begin
                report("segment_pattern", 32'(want.segment_pattern), 32'(got.segment_pattern));
            end
            if (got.digit_select !== want.digit_select) begin
                report("digit_select", 32'(want.digit_select), 32'(got.digit_select));
            end
            if (got.count_value !== want.count_value) begin
                report("count_value", 32'(want.count_value), 32'(got.count_value));
            end
            if (got.select_event !== want.select_event) begin
                report("select_event", 32'(want.select_event), 32'(got.select_event));
            end
            if (got.alt_event !== want.alt_event) begin
                report("alt_event", 32'(want.alt_event), 32'(got.alt_event));
            end
        endfunction

        function int pending();
            return awaited_digits.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // Fields from bit 0: plus_level, minus_level, select_level, alt_level.
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // Fields from bit 0: segment_pattern[7:0], digit_select[3:0],
    // count_value[6:0], select_event, alt_event.
    logic [23:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tick_predictor predictor = new();
    int send_idle = 0;
    int recv_idle = 0;
    int cur_threshold = int'(DEBOUNCE_TICKS_RESET);
    bit held [NUM_BUTTONS] = '{default: 1'b0};
    int run_left [NUM_BUTTONS] = '{default: 0};

    debounced_updown_counter_7seg_scan #(
        .TICK_COUNT_WIDTH(TICK_W)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            predictor.check_digit_beat(result_t'(m_tdata[20:0]));
        end
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_tick(input logic [3:0] levels);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, levels};
        do @(posedge aclk); while (!s_tready);
        predictor.note_tick(levels);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (predictor.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        predictor.set_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Buttons follow press and release runs; a few ticks are random noise.
    function automatic logic [3:0] next_levels(bit minus_quiet);
        logic [3:0] lv;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (run_left[b] == 0) begin
                held[b] = !held[b];
                run_left[b] = held[b] ? $urandom_range(cur_threshold + 4, 1)
                                      : $urandom_range(3, 1);
            end
            run_left[b]--;
            lv[b] = held[b];
            if ($urandom_range(99) < 8) begin
                lv[b] = 1'($urandom_range(1));
            end
            if (minus_quiet && b == BTN_MINUS) begin
                lv[b] = 1'b0;
            end
        end
        return lv;
    endfunction

    task automatic run_phase(input int threshold, input int limit, input bit minus_quiet,
                             input int ticks);
        wait_drained();
        cur_threshold = threshold;
        write_reg(REG_DEBOUNCE_TICKS, ($urandom() & 32'hffff_fff0) | threshold);
        write_reg(REG_MAX_COUNT, ($urandom() & 32'hffff_ff80) | limit);
        repeat (ticks) begin
            send_tick(next_levels(minus_quiet));
        end
    endtask

    initial begin
        logic [3:0] opening [15] = '{
            4'b0000, 4'b1111, 4'b1111, 4'b1111, 4'b1111, 4'b0000,
            4'b0010, 4'b0010, 4'b0010, 4'b0000,
            4'b0001, 4'b0001, 4'b0000, 4'b0001, 4'b0000
        };
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle = 16;
        recv_idle = 72;
        foreach (opening[i]) begin
            send_tick(opening[i]);
        end
        // Hold alt partway under a high threshold, then lower the threshold.
        wait_drained();
        write_reg(REG_DEBOUNCE_TICKS, 32'd9);
        repeat (4) send_tick(4'b1000);
        wait_drained();
        write_reg(REG_DEBOUNCE_TICKS, 32'd2);
        send_tick(4'b1000);
        send_tick(4'b0000);

        run_phase(1, 3, 1'b1, 120);
        run_phase(15, 0, 1'b0, 150);
        send_idle = 72;
        recv_idle = 16;
        run_phase(0, 127, 1'b1, 350);
        run_phase(3, 127, 1'b1, 250);
        send_idle = 0;
        recv_idle = 0;
        run_phase(2, 50, 1'b0, 300);
        run_phase($urandom_range(15, 1), $urandom_range(99, 0), 1'b0, 280);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (predictor.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
src/dusc_pkg.sv
src/debounced_updown_counter_7seg_scan.sv
sim/debounced_updown_counter_7seg_scan_tb.sv
